/* src/kvl_pkg.sv */
// shared types and constants for the key/value line lookup block
package kvl_pkg;

  localparam int unsigned KEY_SLOTS   = 8;
  localparam int unsigned LABEL_CHARS = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // "label", first character in the low byte
  localparam logic [8*LABEL_CHARS-1:0] LABEL_WORD = 40'h6c_65_62_61_6c;

  localparam logic CFG_KEY_TEXT   = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_WORD  = 3'd1,
    PH_SEP   = 3'd2,
    PH_VALUE = 3'd3,
    PH_SKIP  = 3'd4
  } phase_e;

  typedef struct packed {
    logic                   zero;
    logic                   last;
    logic                   blank;
    logic                   nl;
    logic [LABEL_CHARS-1:0] lmatch;
    logic [KEY_SLOTS-1:0]   kmatch;
  } byte_cls_t;

endpackage

/* src/kvl_chan_if.sv */
// request and result channel interfaces
interface kvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source(output valid, text_byte, last_byte, input ready);
  modport sink(input valid, text_byte, last_byte, output ready);
endinterface

interface kvl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] value_offset;
  logic [15:0] value_length;
  modport source(output valid, status, value_offset, value_length, input ready);
  modport sink(input valid, status, value_offset, value_length, output ready);
endinterface

/* src/config_key_value_line_lookup.sv */
// top level of the key/value line lookup block
//
// in_req carries the text one byte per request (text_byte, last_byte) under
// valid/ready; a zero byte or a request with last_byte set ends the text.
// out_rsp carries at most one result per text: status, value_offset and
// value_length. key_text and key_length are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them only while no text is in flight, the block does not enforce it.
// Throughput is one byte per cycle while out_rsp takes results; the scanner
// state update for one byte is the loop that sets this figure.
// The accepted byte that decides the result passes through the front queue
// and then the result register before out_rsp.valid rises.
// A four-entry queue decouples the classifying front from the scanner, so
// in_req.ready only drops when the queue fills. When out_rsp stalls with a
// result held, the scanner pauses and bytes collect in the queue.
// Reset empties the queue and result register, clears key_text, sets
// key_length to one and arms the scanner for a new text.
module config_key_value_line_lookup #(
  parameter int unsigned KEY_MAX_CHARS  = 8,
  parameter int unsigned TEXT_MAX_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kvl_in_if.sink      in_req,
  kvl_out_if.source   out_rsp,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import kvl_pkg::*;

  logic [63:0] key_text_q;
  logic [3:0]  key_length_q;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  byte_cls_t   cls_in;
  byte_cls_t   cls_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q   <= '0;
      key_length_q <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_KEY_TEXT) begin
        key_text_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_KEY_LENGTH) begin
        key_length_q <= cfg_data_i[3:0];
      end
    end
  end

  kvl_front #(
    .KEY_MAX_CHARS(KEY_MAX_CHARS)
  ) u_front (
    .in_req    (in_req),
    .key_text_i(key_text_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .cls_o     (cls_in)
  );

  kvl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_in),
    .pop_i  (pop),
    .data_o (cls_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  kvl_back #(
    .KEY_MAX_CHARS (KEY_MAX_CHARS),
    .TEXT_MAX_BYTES(TEXT_MAX_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_text_i  (key_text_q),
    .key_length_i(key_length_q),
    .q_empty_i   (q_empty),
    .cls_i       (cls_out),
    .pop_o       (pop),
    .out_rsp     (out_rsp)
  );

endmodule

/* src/kvl_front.sv */
// front end: accepts text bytes and classifies them against the key and "label"
module kvl_front #(
  parameter int unsigned KEY_MAX_CHARS = 8
) (
  kvl_in_if.sink                   in_req,
  input  logic [63:0]              key_text_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output kvl_pkg::byte_cls_t       cls_o
);
  import kvl_pkg::*;

  logic [7:0] c;

  assign c            = in_req.text_byte;
  assign in_req.ready = !q_full_i;
  assign push_o       = in_req.valid && !q_full_i;

  always_comb begin
    cls_o.zero  = (c == CH_NUL);
    cls_o.last  = in_req.last_byte;
    cls_o.blank = (c == CH_SPACE) || (c == CH_TAB);
    cls_o.nl    = (c == CH_NL);
    for (int i = 0; i < LABEL_CHARS; i++) begin
      cls_o.lmatch[i] = (c == LABEL_WORD[8*i +: 8]);
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      cls_o.kmatch[i] = (i < KEY_MAX_CHARS) && (c == key_text_i[8*i +: 8]);
    end
  end

endmodule

/* src/kvl_queue.sv */
// short queue of classified bytes between front and back
module kvl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kvl_pkg::byte_cls_t data_i,
  input  logic               pop_i,
  output kvl_pkg::byte_cls_t data_o,
  output logic               full_o,
  output logic               empty_o
);
  import kvl_pkg::*;

  byte_cls_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/kvl_back.sv */
// back end: line scanner state machine and result register
module kvl_back #(
  parameter int unsigned KEY_MAX_CHARS  = 8,
  parameter int unsigned TEXT_MAX_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        key_text_i,
  input  logic [3:0]         key_length_i,
  input  logic               q_empty_i,
  input  kvl_pkg::byte_cls_t cls_i,
  output logic               pop_o,
  kvl_out_if.source          out_rsp
);
  import kvl_pkg::*;

  localparam int unsigned KIW = $clog2(KEY_MAX_CHARS + 1);
  localparam int unsigned PW  = $clog2(TEXT_MAX_BYTES) + 1;
  localparam logic [PW-1:0] POS_MAX = PW'(TEXT_MAX_BYTES);

  phase_e        phase_q, phase_d;
  logic [KIW-1:0] kidx_q, kidx_d;
  logic          kal_q, kal_d;
  logic [2:0]    lidx_q, lidx_d;
  logic          lal_q, lal_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   vstart_q, vstart_d;
  logic [15:0]   lnb_q, lnb_d;
  logic          first_q, first_d;
  logic          indent_q, indent_d;
  logic          done_q, done_d;

  logic          ovalid_q;
  status_e       ostat_q, ostat_d;
  logic [15:0]   ooff_q, ooff_d;
  logic [15:0]   olen_q, olen_d;
  logic          emit;

  logic [KIW-1:0] eff_len;
  logic           key_usable;
  logic           key_is_label;

  logic           lead;
  logic [KIW-1:0] f_kidx_in;
  logic           f_kal_in;
  logic [2:0]     f_lidx_in;
  logic           f_lal_in;
  logic [KEY_SLOTS-1:0]   kshift;
  logic [LABEL_CHARS-1:0] lshift;
  logic [KIW-1:0] f_kidx;
  logic           f_kal;
  logic [2:0]     f_lidx;
  logic           f_lal;
  logic [15:0]    pos16;

  always_comb begin
    if (key_length_i > 4'(KEY_MAX_CHARS)) begin
      eff_len = KIW'(KEY_MAX_CHARS);
    end else begin
      eff_len = KIW'(key_length_i);
    end
    key_usable = (eff_len != '0);
    for (int i = 0; i < KEY_MAX_CHARS; i++) begin
      if ((i < 32'(eff_len)) &&
          ((key_text_i[8*i +: 8] == CH_NUL) || (key_text_i[8*i +: 8] == CH_SPACE) ||
           (key_text_i[8*i +: 8] == CH_TAB) || (key_text_i[8*i +: 8] == CH_NL))) begin
        key_usable = 1'b0;
      end
    end
    key_is_label = (4'(eff_len) == 4'(LABEL_CHARS)) &&
                   (key_text_i[8*LABEL_CHARS-1:0] == LABEL_WORD);
  end

  // word matcher step, restarted at the first non-blank character of a line
  assign lead      = (phase_q == PH_LEAD);
  assign f_kidx_in = lead ? '0 : kidx_q;
  assign f_kal_in  = lead ? 1'b1 : kal_q;
  assign f_lidx_in = lead ? '0 : lidx_q;
  assign f_lal_in  = lead ? 1'b1 : lal_q;
  assign kshift    = cls_i.kmatch >> f_kidx_in;
  assign lshift    = cls_i.lmatch >> f_lidx_in;

  always_comb begin
    if (f_kal_in && key_usable && (f_kidx_in < eff_len) && kshift[0]) begin
      f_kal  = 1'b1;
      f_kidx = f_kidx_in + 1'b1;
    end else begin
      f_kal  = 1'b0;
      f_kidx = f_kidx_in;
    end
    if (f_lal_in && (f_lidx_in < 3'(LABEL_CHARS)) && lshift[0]) begin
      f_lal  = 1'b1;
      f_lidx = f_lidx_in + 1'b1;
    end else begin
      f_lal  = 1'b0;
      f_lidx = f_lidx_in;
    end
  end

  assign pos16 = 16'(pos_q);
  assign pop_o = !q_empty_i && (!ovalid_q || out_rsp.ready);

  always_comb begin
    phase_d  = phase_q;
    kidx_d   = kidx_q;
    kal_d    = kal_q;
    lidx_d   = lidx_q;
    lal_d    = lal_q;
    pos_d    = pos_q;
    vstart_d = vstart_q;
    lnb_d    = lnb_q;
    first_d  = first_q;
    indent_d = indent_q;
    done_d   = done_q;
    emit     = 1'b0;
    ostat_d  = ST_NONE;
    ooff_d   = '0;
    olen_d   = '0;

    if (pop_o) begin
      if (!cls_i.zero && !done_q) begin
        if (pos_q == POS_MAX) begin
          emit    = 1'b1;
          ostat_d = ST_LONG;
        end else begin
          unique case (phase_q)
            PH_LEAD: begin
              if (cls_i.blank) begin
                if (first_q) begin
                  indent_d = 1'b1;
                end
              end else if (cls_i.nl) begin
                phase_d = PH_LEAD;
                first_d = 1'b0;
              end else begin
                kidx_d  = f_kidx;
                kal_d   = f_kal;
                lidx_d  = f_lidx;
                lal_d   = f_lal;
                phase_d = PH_WORD;
              end
            end
            PH_WORD: begin
              if (cls_i.blank) begin
                kal_d   = kal_q && (kidx_q == eff_len);
                lal_d   = lal_q && (lidx_q == 3'(LABEL_CHARS));
                phase_d = ((kal_q && (kidx_q == eff_len)) ||
                           (lal_q && (lidx_q == 3'(LABEL_CHARS)))) ? PH_SEP : PH_SKIP;
              end else if (cls_i.nl) begin
                phase_d = PH_LEAD;
                first_d = 1'b0;
              end else begin
                kidx_d = f_kidx;
                kal_d  = f_kal;
                lidx_d = f_lidx;
                lal_d  = f_lal;
              end
            end
            PH_SEP: begin
              if (cls_i.blank) begin
                phase_d = PH_SEP;
              end else if (cls_i.nl) begin
                phase_d = PH_LEAD;
                first_d = 1'b0;
              end else if (lal_q && !key_is_label) begin
                // entry header line is skipped, any other label line ends the search
                if (first_q && !indent_q) begin
                  phase_d = PH_SKIP;
                end else begin
                  emit    = 1'b1;
                  ostat_d = ST_NONE;
                end
              end else if (kal_q) begin
                vstart_d = pos16;
                lnb_d    = pos16;
                phase_d  = PH_VALUE;
              end else begin
                phase_d = PH_SKIP;
              end
            end
            PH_VALUE: begin
              if (cls_i.nl) begin
                emit    = 1'b1;
                ostat_d = ST_FOUND;
                ooff_d  = vstart_q;
                olen_d  = lnb_q - vstart_q + 16'd1;
              end else if (!cls_i.blank) begin
                lnb_d = pos16;
              end
            end
            PH_SKIP: begin
              if (cls_i.nl) begin
                phase_d = PH_LEAD;
                first_d = 1'b0;
              end
            end
            default: begin
              phase_d = PH_SKIP;
            end
          endcase
        end
        if (emit) begin
          done_d = 1'b1;
        end
      end

      if (!cls_i.zero && (pos_q != POS_MAX)) begin
        pos_d = pos_q + 1'b1;
      end

      // end of text: report if nothing was reported yet, then rearm
      if (cls_i.zero || cls_i.last) begin
        if (!done_d) begin
          emit = 1'b1;
          if (phase_d == PH_VALUE) begin
            ostat_d = ST_FOUND;
            ooff_d  = vstart_d;
            olen_d  = lnb_d - vstart_d + 16'd1;
          end else begin
            ostat_d = ST_NONE;
          end
        end
        phase_d  = PH_LEAD;
        kidx_d   = '0;
        kal_d    = 1'b1;
        lidx_d   = '0;
        lal_d    = 1'b1;
        pos_d    = '0;
        vstart_d = '0;
        lnb_d    = '0;
        first_d  = 1'b1;
        indent_d = 1'b0;
        done_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      kidx_q   <= '0;
      kal_q    <= 1'b1;
      lidx_q   <= '0;
      lal_q    <= 1'b1;
      pos_q    <= '0;
      vstart_q <= '0;
      lnb_q    <= '0;
      first_q  <= 1'b1;
      indent_q <= 1'b0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      kidx_q   <= kidx_d;
      kal_q    <= kal_d;
      lidx_q   <= lidx_d;
      lal_q    <= lal_d;
      pos_q    <= pos_d;
      vstart_q <= vstart_d;
      lnb_q    <= lnb_d;
      first_q  <= first_d;
      indent_q <= indent_d;
      done_q   <= done_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ostat_q <= ostat_d;
      ooff_q  <= ooff_d;
      olen_q  <= olen_d;
    end
  end

  assign out_rsp.valid        = ovalid_q;
  assign out_rsp.status       = ostat_q;
  assign out_rsp.value_offset = ooff_q;
  assign out_rsp.value_length = olen_q;

endmodule

/* tb/config_key_value_line_lookup_tb.sv */
// testbench for the key/value line lookup block, texts checked against a line scanner model
module config_key_value_line_lookup_tb;
  import kvl_pkg::*;

  localparam int TEXT_LIMIT    = 65536;
  localparam int KEY_CAP       = 8;
  localparam int RANDOM_BYTES  = 1250;
  localparam int PHASE_BYTES   = 120;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
    logic [15:0] length;
  } lookup_rsp_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        req_valid = 1'b0;
  logic [7:0]  req_byte  = 8'h00;
  logic        req_last  = 1'b0;
  logic        rsp_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_KEY_TEXT;
  logic [63:0] cfg_data  = '0;

  kvl_in_if  req_if ();
  kvl_out_if rsp_if ();

  assign req_if.valid     = req_valid;
  assign req_if.text_byte = req_byte;
  assign req_if.last_byte = req_last;
  assign rsp_if.ready     = rsp_ready;

  config_key_value_line_lookup dut (
    .clk_i,
    .rst_ni,
    .in_req     (req_if),
    .out_rsp    (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scanner model state and its copy of the key registers
  logic [63:0] key_txt;
  logic [3:0]  key_len;
  phase_e      scan_ph;
  logic [3:0]  key_idx;
  logic        key_ok;
  logic [2:0]  lbl_idx;
  logic        lbl_ok;
  logic [16:0] scan_pos;
  logic [15:0] val_start;
  logic [15:0] val_end;
  logic        first_line;
  logic        first_indented;
  logic        scan_done;

  text_req_t   pending_bytes_q[$];
  lookup_rsp_t expected_lookup_q[$];
  int          err_count = 0;

  text_req_t   req_next;
  int          req_gap;
  logic        req_burst;
  lookup_rsp_t rsp_exp;
  int          rsp_stall;
  int          stall_next;
  logic        rsp_burst;

  function automatic logic [3:0] key_eff_len();
    return (key_len > KEY_CAP) ? 4'(KEY_CAP) : key_len;
  endfunction

  function automatic logic [7:0] key_char(input int i);
    return key_txt[8*i +: 8];
  endfunction

  function automatic logic key_usable();
    logic [7:0] ch;
    int i;
    if (key_eff_len() == 0) return 1'b0;
    for (i = 0; i < key_eff_len(); i++) begin
      ch = key_char(i);
      if (ch == CH_NUL || ch == CH_SPACE || ch == CH_TAB || ch == CH_NL) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic key_is_label();
    return key_eff_len() == 4'd5 && key_txt[8*LABEL_CHARS-1:0] == LABEL_WORD;
  endfunction

  function automatic lookup_rsp_t value_rsp();
    return '{ST_FOUND, val_start, val_end - val_start + 16'd1};
  endfunction

  function automatic lookup_rsp_t close_text();
    if (scan_ph == PH_VALUE) return value_rsp();
    return '{ST_NONE, 16'd0, 16'd0};
  endfunction

  task automatic rearm_scan();
    scan_ph        = PH_LEAD;
    key_idx        = '0;
    key_ok         = 1'b1;
    lbl_idx        = '0;
    lbl_ok         = 1'b1;
    scan_pos       = '0;
    val_start      = '0;
    val_end        = '0;
    first_line     = 1'b1;
    first_indented = 1'b0;
    scan_done      = 1'b0;
  endtask

  task automatic line_break();
    scan_ph    = PH_LEAD;
    first_line = 1'b0;
  endtask

  task automatic feed_word(input logic [7:0] c);
    if (key_ok && key_usable() && key_idx < key_eff_len() && c == key_char(key_idx)) begin
      key_idx++;
    end else begin
      key_ok = 1'b0;
    end
    if (lbl_ok && lbl_idx < LABEL_CHARS && c == LABEL_WORD[8*lbl_idx +: 8]) begin
      lbl_idx++;
    end else begin
      lbl_ok = 1'b0;
    end
  endtask

  task automatic scan_char(input logic [7:0] c, output logic got, output lookup_rsp_t rsp);
    logic blank;
    logic nl;
    got   = 1'b0;
    rsp   = '{ST_NONE, 16'd0, 16'd0};
    blank = (c == CH_SPACE || c == CH_TAB);
    nl    = (c == CH_NL);
    case (scan_ph)
      PH_LEAD: begin
        if (blank) begin
          if (first_line) first_indented = 1'b1;
        end else if (nl) begin
          line_break();
        end else begin
          key_idx = '0;
          key_ok  = 1'b1;
          lbl_idx = '0;
          lbl_ok  = 1'b1;
          feed_word(c);
          scan_ph = PH_WORD;
        end
      end
      PH_WORD: begin
        if (blank) begin
          key_ok  = key_ok && key_idx == key_eff_len();
          lbl_ok  = lbl_ok && lbl_idx == LABEL_CHARS;
          scan_ph = (key_ok || lbl_ok) ? PH_SEP : PH_SKIP;
        end else if (nl) begin
          line_break();
        end else begin
          feed_word(c);
        end
      end
      PH_SEP: begin
        if (nl) begin
          line_break();
        end else if (!blank) begin
          if (lbl_ok && !key_is_label()) begin
            // unindented label on the first line is the entry header
            if (first_line && !first_indented) begin
              scan_ph = PH_SKIP;
            end else begin
              got       = 1'b1;
              scan_done = 1'b1;
            end
          end else if (key_ok) begin
            val_start = scan_pos[15:0];
            val_end   = scan_pos[15:0];
            scan_ph   = PH_VALUE;
          end else begin
            scan_ph = PH_SKIP;
          end
        end
      end
      PH_VALUE: begin
        if (nl) begin
          got       = 1'b1;
          rsp       = value_rsp();
          scan_done = 1'b1;
        end else if (!blank) begin
          val_end = scan_pos[15:0];
        end
      end
      default: begin
        if (nl) line_break();
        else scan_ph = PH_SKIP;
      end
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic last);
    logic        got;
    lookup_rsp_t rsp;
    got = 1'b0;
    rsp = '{ST_NONE, 16'd0, 16'd0};
    if (c == CH_NUL) begin
      if (!scan_done) begin
        rsp = close_text();
        got = 1'b1;
      end
      rearm_scan();
    end else begin
      if (!scan_done) begin
        if (scan_pos >= TEXT_LIMIT) begin
          rsp       = '{ST_LONG, 16'd0, 16'd0};
          got       = 1'b1;
          scan_done = 1'b1;
        end else begin
          scan_char(c, got, rsp);
        end
      end
      if (scan_pos < TEXT_LIMIT) scan_pos++;
      if (last) begin
        if (!got && !scan_done) begin
          rsp = close_text();
          got = 1'b1;
        end
        rearm_scan();
      end
    end
    if (got) expected_lookup_q.push_back(rsp);
  endtask

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
      req_burst <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) scan_byte(req_byte, req_last);
      if (!req_valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (pending_bytes_q.size() != 0) begin
          req_next  = pending_bytes_q.pop_front();
          req_valid <= 1'b1;
          req_byte  <= req_next.data;
          req_last  <= req_next.last;
          req_gap   <= req_burst ? 0 : $urandom_range(0, 3);
          if ($urandom_range(0, 31) == 0) req_burst <= !req_burst;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
      rsp_burst <= 1'b0;
    end else begin
      stall_next = rsp_stall;
      if (rsp_if.valid && rsp_ready) begin
        if (expected_lookup_q.size() == 0) begin
          report($sformatf("unexpected result: status %0d offset %0d length %0d",
                           rsp_if.status, rsp_if.value_offset, rsp_if.value_length));
        end else begin
          rsp_exp = expected_lookup_q.pop_front();
          if (rsp_if.status != rsp_exp.status)
            report($sformatf("status mismatch: expected %0d, got %0d",
                             rsp_exp.status, rsp_if.status));
          if (rsp_if.value_offset != rsp_exp.offset)
            report($sformatf("offset mismatch: expected %0d, got %0d",
                             rsp_exp.offset, rsp_if.value_offset));
          if (rsp_if.value_length != rsp_exp.length)
            report($sformatf("length mismatch: expected %0d, got %0d",
                             rsp_exp.length, rsp_if.value_length));
        end
        stall_next = rsp_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) rsp_burst <= !rsp_burst;
      end else if (rsp_if.valid && stall_next != 0) begin
        stall_next--;
      end
      rsp_ready <= (stall_next == 0);
      rsp_stall <= stall_next;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    pending_bytes_q.push_back('{b, last});
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic mark_last();
    pending_bytes_q[pending_bytes_q.size()-1].last = 1'b1;
  endtask

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] rand_value_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [63:0] rand_letters();
    logic [63:0] k;
    int i;
    for (i = 0; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(97, 122));
    return k;
  endfunction

  task automatic push_key_word(input int n);
    int i;
    if (n == 0) push_byte(8'($urandom_range(97, 122)), 1'b0);
    for (i = 0; i < n; i++) push_byte(key_char(i), 1'b0);
  endtask

  task automatic push_value();
    if ($urandom_range(0, 7) != 0) repeat ($urandom_range(1, 3)) push_byte(rand_blank(), 1'b0);
    if ($urandom_range(0, 7) != 0) begin
      repeat ($urandom_range(1, 6))
        push_byte(($urandom_range(0, 5) == 0) ? rand_blank() : rand_value_char(), 1'b0);
      repeat ($urandom_range(0, 2)) push_byte(rand_blank(), 1'b0);
    end
    push_byte(CH_NL, 1'b0);
  endtask

  task automatic gen_line();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) push_byte(rand_blank(), 1'b0);
    n = key_eff_len();
    case ($urandom_range(0, 11)) inside
      [0:3]: push_key_word(n);
      [4:5]: push_text("label");
      6: push_key_word((n > 1) ? n - 1 : n);
      7: begin
        push_key_word(n);
        push_byte(rand_value_char(), 1'b0);
      end
      8: repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(97, 122)), 1'b0);
      9: push_text("lab");
      10: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(1, 255)), 1'b0);
      default: begin
        push_byte(CH_NL, 1'b0);
        return;
      end
    endcase
    push_value();
  endtask

  task automatic gen_text();
    // entry header
    if ($urandom_range(0, 3) == 0) begin
      push_text("label ");
      push_value();
    end
    repeat ($urandom_range(1, 5)) gen_line();
    case ($urandom_range(0, 3))
      0: mark_last();
      1: push_byte(CH_NUL, 1'($urandom_range(0, 1)));
      2: begin
        // text ends inside an unterminated line
        void'(pending_bytes_q.pop_back());
        push_byte(rand_value_char(), 1'b1);
      end
      default: push_byte(8'($urandom_range(1, 255)), 1'b1);
    endcase
    if ($urandom_range(0, 9) == 0) push_byte(CH_NUL, 1'b0);
  endtask

  task automatic write_key(input logic [63:0] txt, input logic [3:0] len);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_TEXT;
    cfg_data  <= txt;
    @(posedge clk_i);
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data  <= {60'd0, len};
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    key_txt = txt;
    key_len = len;
  endtask

  task automatic wait_idle();
    while (pending_bytes_q.size() != 0 || req_valid || expected_lookup_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase;
    int sent;
    int phase_bytes;
    int mark;
    key_txt = '0;
    key_len = 4'd1;
    rearm_scan();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty text under the reset key
    push_byte(CH_NUL, 1'b0);
    wait_idle();

    write_key(64'h6261, 4'd2);
    push_text("label h\n ab ");
    push_byte(8'hff, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_text("ab z");
    push_byte(CH_NUL, 1'b0);
    push_text(" label z");
    mark_last();
    push_text("ab ");
    push_byte(8'h80, 1'b0);
    push_text(" q");
    push_byte(CH_TAB, 1'b1);
    push_byte(CH_NUL, 1'b1);
    wait_idle();

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_BYTES) begin
      case (phase)
        0: write_key('0, 4'd0);
        1: write_key('1, 4'd15);
        2: write_key({24'd0, LABEL_WORD}, 4'd5);
        3: write_key(64'h622061, 4'd3);
        4: write_key(rand_letters(), 4'd1);
        5: write_key(rand_letters(), 4'd8);
        default: write_key(rand_letters(), 4'($urandom_range(1, 10)));
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        mark = pending_bytes_q.size();
        gen_text();
        phase_bytes += pending_bytes_q.size() - mark;
      end
      sent += phase_bytes;
      wait_idle();
      phase++;
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
